[hw/rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions in the LZSS ring decompressor.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define LRD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define LRD_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/lrd_pkg.sv]
// ---------------------------------------------------------------------------
// lrd_pkg
// Constants shared by the LZSS ring decompressor and its channel interfaces.
// ---------------------------------------------------------------------------
package lrd_pkg;

   localparam int unsigned BYTE_W         = 8;
   localparam int unsigned RING_SIZE_DEF  = 4096;
   // write position starts this far below the top of the ring
   localparam int unsigned RING_LOOKAHEAD = 18;
   localparam int unsigned HEADER_BYTES   = 4;
   localparam int unsigned FLAG_COUNT     = 8;
   localparam int unsigned LEN_BIAS       = 3;
   localparam int unsigned DIST_W         = 12;
   // output limit is header byte 0 in units of 2^22 bytes
   localparam int unsigned UNIT_SHIFT     = 22;
   localparam int unsigned EMIT_W         = BYTE_W + UNIT_SHIFT;
   localparam logic [BYTE_W-1:0] FILL_BYTE = 8'hFF;

endpackage

[hw/rtl/lrd_if.sv]
// ---------------------------------------------------------------------------
// LZSS decompressor channels
// Valid/ready channels for compressed input words and decoded output words.
// ---------------------------------------------------------------------------
interface lrd_req_if;
   logic                       valid;
   logic                       ready;
   logic [lrd_pkg::BYTE_W-1:0] in_byte;
   logic                       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface lrd_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [lrd_pkg::BYTE_W-1:0] out_byte;
   logic                       out_last;

   modport source (output valid, output out_byte, output out_last, input ready);
   modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

[hw/rtl/lzss_ring_decompressor.sv]
// ---------------------------------------------------------------------------
// lzss_ring_decompressor
// LZSS stream decoder with a 4 KiB history ring held in one synchronous RAM.
// ---------------------------------------------------------------------------
// Takes one compressed word per handshake and returns decoded bytes, one per
// output word. A literal yields one byte; a reference spans two words and
// copies 3 to 18 bytes, with one ring read and one output word per cycle
// while the output register can move. The next word is taken only once the
// copy sequencer is idle and the output register can move. After reset and
// after every word marked last, the ring reads as all 0xFF through a fill
// count, so there is no clearing pass.
`include "assert_macros.svh"

module lzss_ring_decompressor #(
   parameter int unsigned RING_SIZE = lrd_pkg::RING_SIZE_DEF
) (
   input logic        clock,
   input logic        reset,
   lrd_req_if.sink    req_ch,
   lrd_rsp_if.source  rsp_ch
);

   localparam int unsigned AW    = $clog2(RING_SIZE);
   localparam int unsigned LEN_W = $clog2(15 + lrd_pkg::LEN_BIAS + 1);
   localparam int unsigned BW    = lrd_pkg::BYTE_W;
   localparam int unsigned EW    = lrd_pkg::EMIT_W;
   localparam logic [AW-1:0] RING_START = AW'(RING_SIZE - lrd_pkg::RING_LOOKAHEAD);
   localparam logic [AW:0]   FILL_FULL  = (AW+1)'(RING_SIZE);

   typedef enum logic {ST_IDLE, ST_COPY} state_type;

   typedef struct packed {
      logic          valid;
      logic          lit;      // byte comes from the input word
      logic          fwd;      // byte comes from the previous write
      logic          ok;       // ring entry written in this stream
      logic          emit;
      logic          last;
      logic [AW-1:0] addr;
      logic [BW-1:0] lit_byte;
   } wr_stage_type;

   logic [BW-1:0] ring_mem [RING_SIZE];

   state_type               state_ff, state_in;
   logic [AW-1:0]           wp_ff, wp_in;
   logic [AW:0]             fill_ff, fill_in;
   logic [EW-1:0]           emitted_ff, emitted_in;
   logic [BW-1:0]           size_units_ff, size_units_in;
   logic [2:0]              header_count_ff, header_count_in;
   logic [BW-1:0]           flag_bits_ff, flag_bits_in;
   logic [3:0]              flags_left_ff, flags_left_in;
   logic                    ref_pending_ff, ref_pending_in;
   logic [BW-1:0]           ref_high_ff, ref_high_in;
   logic [lrd_pkg::DIST_W-1:0] dist_ff, dist_in;
   logic [LEN_W-1:0]        len_ff, len_in;
   logic                    last_ff, last_in;
   wr_stage_type            w_ff, w_in;
   logic [BW-1:0]           fwd_byte_ff, fwd_byte_in;
   logic                    out_valid_ff, out_valid_in;
   logic [BW-1:0]           out_byte_ff, out_byte_in;
   logic                    out_last_ff, out_last_in;
   logic [BW-1:0]           ring_rd_ff;

   logic          advance, accept;
   logic          in_hdr, in_flag, in_lit, in_ref1, in_ref2;
   logic          issue_lit, issue_copy, issue, issue_final;
   logic          parser_clear, ring_clear;
   logic [EW-1:0] limit;
   logic          emit_ok, hit_limit;
   logic [AW-1:0] src_addr, src_off;
   logic          src_ok;
   logic [BW-1:0] w_data;

   // output register moves when empty or taken
   assign advance = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE) && advance;
   assign accept = req_ch.valid && req_ch.ready;

   assign in_hdr  = header_count_ff < 3'(lrd_pkg::HEADER_BYTES);
   assign in_flag = !in_hdr && (flags_left_ff == '0);
   assign in_lit  = !in_hdr && !in_flag && !flag_bits_ff[BW-1];
   assign in_ref1 = !in_hdr && !in_flag && flag_bits_ff[BW-1] && !ref_pending_ff;
   assign in_ref2 = !in_hdr && !in_flag && flag_bits_ff[BW-1] && ref_pending_ff;

   assign issue_lit   = accept && in_lit;
   assign issue_copy  = (state_ff == ST_COPY) && advance;
   assign issue       = issue_lit || issue_copy;
   assign issue_final = issue_lit || (len_ff == LEN_W'(1));

   assign parser_clear = accept && req_ch.in_last;
   assign ring_clear   = (parser_clear && !in_ref2) || (issue_copy && issue_final && last_ff);

   assign limit     = EW'({size_units_ff, {lrd_pkg::UNIT_SHIFT{1'b0}}});
   assign emit_ok   = emitted_ff < limit;
   assign hit_limit = EW'(emitted_ff + 1'b1) == limit;

   // source trails the write position by distance + 1
   assign src_addr = wp_ff - AW'(dist_ff) - AW'(1);
   assign src_off  = src_addr - RING_START;
   assign src_ok   = {1'b0, src_off} < fill_ff;

   always_comb begin
      if (w_ff.lit) begin
         w_data = w_ff.lit_byte;
      end else if (w_ff.fwd) begin
         w_data = fwd_byte_ff;
      end else if (w_ff.ok) begin
         w_data = ring_rd_ff;
      end else begin
         w_data = lrd_pkg::FILL_BYTE;
      end
   end

   always_comb begin
      state_in        = state_ff;
      wp_in           = wp_ff;
      fill_in         = fill_ff;
      emitted_in      = emitted_ff;
      size_units_in   = size_units_ff;
      header_count_in = header_count_ff;
      flag_bits_in    = flag_bits_ff;
      flags_left_in   = flags_left_ff;
      ref_pending_in  = ref_pending_ff;
      ref_high_in     = ref_high_ff;
      dist_in         = dist_ff;
      len_in          = len_ff;
      last_in         = last_ff;
      w_in            = w_ff;
      fwd_byte_in     = fwd_byte_ff;
      out_valid_in    = out_valid_ff;
      out_byte_in     = out_byte_ff;
      out_last_in     = out_last_ff;

      if (advance) begin
         w_in.valid   = 1'b0;
         out_valid_in = w_ff.valid && w_ff.emit;
         out_byte_in  = w_data;
         out_last_in  = w_ff.last;
      end

      if (issue) begin
         w_in.valid    = 1'b1;
         w_in.lit      = issue_lit;
         w_in.lit_byte = req_ch.in_byte;
         w_in.addr     = wp_ff;
         // read of the entry being written this cycle sees old RAM data
         w_in.fwd      = w_ff.valid && (src_addr == w_ff.addr);
         w_in.ok       = src_ok;
         w_in.emit     = emit_ok;
         w_in.last     = emit_ok && (issue_final || hit_limit);
         fwd_byte_in   = w_data;
         wp_in         = wp_ff + AW'(1);
         if (fill_ff != FILL_FULL) begin
            fill_in = fill_ff + (AW+1)'(1);
         end
         if (emit_ok) begin
            emitted_in = emitted_ff + EW'(1);
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (in_hdr) begin
                  if (header_count_ff == '0) begin
                     size_units_in = req_ch.in_byte;
                  end
                  header_count_in = header_count_ff + 3'd1;
               end else if (in_flag) begin
                  flag_bits_in  = req_ch.in_byte;
                  flags_left_in = 4'(lrd_pkg::FLAG_COUNT);
               end else if (in_lit) begin
                  flag_bits_in  = {flag_bits_ff[BW-2:0], 1'b0};
                  flags_left_in = flags_left_ff - 4'd1;
               end else if (in_ref1) begin
                  ref_high_in    = req_ch.in_byte;
                  ref_pending_in = 1'b1;
               end else begin
                  dist_in        = {ref_high_ff[3:0], req_ch.in_byte};
                  len_in         = LEN_W'(ref_high_ff[7:4]) + LEN_W'(lrd_pkg::LEN_BIAS);
                  ref_pending_in = 1'b0;
                  flag_bits_in   = {flag_bits_ff[BW-2:0], 1'b0};
                  flags_left_in  = flags_left_ff - 4'd1;
                  last_in        = req_ch.in_last;
                  state_in       = ST_COPY;
               end
            end
         end
         ST_COPY: begin
            if (issue_copy) begin
               len_in = len_ff - LEN_W'(1);
               if (issue_final) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // parser restarts at once; ring side waits for the copy to drain
      if (parser_clear) begin
         header_count_in = '0;
         flag_bits_in    = '0;
         flags_left_in   = '0;
         ref_pending_in  = 1'b0;
         ref_high_in     = '0;
      end
      if (ring_clear) begin
         wp_in         = RING_START;
         fill_in       = '0;
         emitted_in    = '0;
         size_units_in = '0;
         last_in       = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         wp_ff           <= RING_START;
         fill_ff         <= '0;
         emitted_ff      <= '0;
         size_units_ff   <= '0;
         header_count_ff <= '0;
         flag_bits_ff    <= '0;
         flags_left_ff   <= '0;
         ref_pending_ff  <= 1'b0;
         ref_high_ff     <= '0;
         len_ff          <= '0;
         last_ff         <= 1'b0;
         w_ff            <= '0;
         out_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         wp_ff           <= wp_in;
         fill_ff         <= fill_in;
         emitted_ff      <= emitted_in;
         size_units_ff   <= size_units_in;
         header_count_ff <= header_count_in;
         flag_bits_ff    <= flag_bits_in;
         flags_left_ff   <= flags_left_in;
         ref_pending_ff  <= ref_pending_in;
         ref_high_ff     <= ref_high_in;
         len_ff          <= len_in;
         last_ff         <= last_in;
         w_ff            <= w_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dist_ff     <= dist_in;
      fwd_byte_ff <= fwd_byte_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   // history ring: one write and one registered read per cycle while the output register can move
   always_ff @(posedge clock) begin
      if (w_ff.valid && advance) begin
         ring_mem[w_ff.addr] <= w_data;
      end
      if (issue_copy) begin
         ring_rd_ff <= ring_mem[src_addr];
      end
   end

   assign rsp_ch.valid    = out_valid_ff;
   assign rsp_ch.out_byte = out_byte_ff;
   assign rsp_ch.out_last = out_last_ff;

   `LRD_ASSERT(a_fill_max, clock, reset, fill_ff <= FILL_FULL, "fill count past ring size")
   `LRD_ASSERT(a_emit_limit, clock, reset, emitted_ff <= limit, "emitted count past limit")
   `LRD_ASSERT(a_copy_len, clock, reset, (state_ff == ST_COPY) |-> (len_ff != '0),
               "copy with zero length")
   `LRD_ASSERT(a_wr_hold, clock, reset,
               (w_ff.valid && !advance) |=> (w_ff.valid && $stable(w_ff.addr)),
               "write stage lost on stall")
   `LRD_ASSERT_NR(a_reset_ring, clock,
                  reset |=> (wp_ff == RING_START && fill_ff == '0 && !out_valid_ff),
                  "ring state not cleared by reset")

endmodule

[verif/tb_lzss_ring_decompressor.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_lzss_ring_decompressor
// Feeds compressed streams into the LZSS ring decompressor and compares every
// decoded byte with bytes typed in the directed table or with a bench decoder.
// The directed table (zero and full limits, literals, references, a cut-off
// reference, a stream that ends in its header) comes first. Random streams
// follow, some of them truncated or pure noise. Both channels idle at random.
// ---------------------------------------------------------------------------
module tb_lzss_ring_decompressor;

   localparam int CLK_HALF       = 10;
   localparam int RESET_CYCLES   = 9;
   localparam int DIRECTED_WORDS = 25;
   localparam int RANDOM_WORDS   = 85;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES    = 40;
   localparam int REPORT_CAP     = 40;
   localparam int BW             = lrd_pkg::BYTE_W;
   localparam int DW             = lrd_pkg::DIST_W;
   localparam int EW             = lrd_pkg::EMIT_W;

   typedef struct {
      logic [BW-1:0] data;
      logic          eos;
      bit            typed;       // expected bytes given in the row
      int            n_typed;
      logic [BW-1:0] typed_byte;
   } stim_word_type;

   typedef struct {
      logic [BW-1:0] data;
      logic          eos;
   } dec_byte_type;

   logic clock;
   logic reset;

   lrd_req_if req_ch ();
   lrd_rsp_if rsp_ch ();

   lzss_ring_decompressor i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      clock = 1'b0;
      #CLK_HALF;
      clock = 1'b1;
      #CLK_HALF;
   end

   // directed streams: limit zero with suppressed output, full limit with
   // every token kind, then a stream that ends inside its header
   stim_word_type dir_table [DIRECTED_WORDS] = '{
      '{8'h00, 1'b0, 1'b1, 0, 8'h00},
      '{8'hFF, 1'b0, 1'b1, 0, 8'h00},
      '{8'h00, 1'b0, 1'b1, 0, 8'h00},
      '{8'h55, 1'b0, 1'b1, 0, 8'h00},
      '{8'h40, 1'b0, 1'b1, 0, 8'h00},
      '{8'h3C, 1'b0, 1'b1, 0, 8'h00},
      '{8'hF0, 1'b0, 1'b1, 0, 8'h00},
      '{8'h00, 1'b1, 1'b1, 0, 8'h00},
      '{8'hFF, 1'b0, 1'b1, 0, 8'h00},
      '{8'h12, 1'b0, 1'b1, 0, 8'h00},
      '{8'h34, 1'b0, 1'b1, 0, 8'h00},
      '{8'h56, 1'b0, 1'b1, 0, 8'h00},
      '{8'hA5, 1'b0, 1'b1, 0, 8'h00},
      '{8'hFF, 1'b0, 1'b1, 0, 8'h00},
      // longest copy from the far end of a freshly cleared ring
      '{8'hFF, 1'b0, 1'b1, 18, 8'hFF},
      '{8'h00, 1'b0, 1'b1, 1, 8'h00},
      '{8'h20, 1'b0, 1'b1, 0, 8'h00},
      '{8'h00, 1'b0, 1'b0, 0, 8'h00},
      '{8'h7E, 1'b0, 1'b1, 1, 8'h7E},
      '{8'h81, 1'b0, 1'b1, 1, 8'h81},
      '{8'h10, 1'b0, 1'b1, 0, 8'h00},
      '{8'h01, 1'b0, 1'b0, 0, 8'h00},
      '{8'hFF, 1'b0, 1'b1, 1, 8'hFF},
      // first reference word, then end of stream: dropped
      '{8'h30, 1'b1, 1'b1, 0, 8'h00},
      '{8'h05, 1'b1, 1'b1, 0, 8'h00}
   };

   // decoder state
   logic [BW-1:0] ring_mem [lrd_pkg::RING_SIZE_DEF];
   logic [DW-1:0] wr_pos;
   logic [2:0]    hdr_cnt;
   logic [BW-1:0] flag_reg;
   logic [3:0]    flags_rem;
   logic          ref_held;
   logic [BW-1:0] ref_hi;
   logic [BW-1:0] limit_units;
   logic [EW-1:0] out_cnt;
   logic [BW-1:0] step_bytes [$];

   stim_word_type stim_q [$];
   stim_word_type stream_q [$];
   dec_byte_type  exp_q [$];

   bit calm;
   int words_sent;
   int streams_sent;
   int bytes_checked;
   int mismatch_cnt;
   int idle_cycles = 0;

   task automatic report_mismatch(input string what);
      mismatch_cnt++;
      if (mismatch_cnt <= REPORT_CAP)
         $display("ERROR @%0t: %s", $time, what);
   endtask

   function automatic void clear_history();
      foreach (ring_mem[i])
         ring_mem[i] = lrd_pkg::FILL_BYTE;
      wr_pos      = DW'(lrd_pkg::RING_SIZE_DEF - lrd_pkg::RING_LOOKAHEAD);
      hdr_cnt     = '0;
      flag_reg    = '0;
      flags_rem   = '0;
      ref_held    = 1'b0;
      ref_hi      = '0;
      limit_units = '0;
      out_cnt     = '0;
   endfunction

   // every decoded byte enters the ring; only those under the limit come out
   function automatic void store_byte(input logic [BW-1:0] c);
      logic [EW-1:0] cap;
      cap = EW'(limit_units) << lrd_pkg::UNIT_SHIFT;
      if (out_cnt < cap) begin
         step_bytes.push_back(c);
         out_cnt++;
      end
      ring_mem[wr_pos] = c;
      wr_pos++;
   endfunction

   function automatic void use_flag();
      flag_reg = flag_reg << 1;
      flags_rem--;
   endfunction

   function automatic void decode_word(input logic [BW-1:0] b, input logic eos);
      logic [DW-1:0] distance;
      logic [DW-1:0] src;
      int            len;
      step_bytes.delete();
      if (hdr_cnt < lrd_pkg::HEADER_BYTES) begin
         if (hdr_cnt == 0)
            limit_units = b;
         hdr_cnt++;
      end else if (flags_rem == 0) begin
         flag_reg  = b;
         flags_rem = 4'(lrd_pkg::FLAG_COUNT);
      end else if (!flag_reg[7]) begin
         store_byte(b);
         use_flag();
      end else if (!ref_held) begin
         ref_hi   = b;
         ref_held = 1'b1;
      end else begin
         distance = {ref_hi[3:0], b};
         len      = int'(ref_hi[7:4]) + int'(lrd_pkg::LEN_BIAS);
         repeat (len) begin
            src = wr_pos - distance - 1'b1;
            store_byte(ring_mem[src]);
         end
         ref_held = 1'b0;
         use_flag();
      end
      if (eos)
         clear_history();
   endfunction

   function automatic int pick_gap();
      int r;
      if (calm)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 50)
         return 0;
      else if (r < 85)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic void push_raw(input logic [BW-1:0] b);
      stim_word_type w;
      w = '{b, 1'b0, 1'b0, 0, 8'h00};
      stream_q.push_back(w);
   endfunction

   // mostly well-formed streams; some truncated anywhere, some raw noise
   task automatic make_stream();
      int            kind;
      int            cut;
      logic [BW-1:0] flags;
      logic [DW-1:0] ref_dist;
      logic [3:0]    len_code;
      stream_q.delete();
      kind = $urandom_range(0, 99);
      if (kind < 10) begin
         repeat ($urandom_range(1, 20))
            push_raw(BW'($urandom));
      end else begin
         push_raw(($urandom_range(0, 7) == 0) ? 8'h00 : BW'($urandom_range(1, 255)));
         repeat (lrd_pkg::HEADER_BYTES - 1)
            push_raw(BW'($urandom));
         repeat ($urandom_range(1, 2)) begin
            flags = BW'($urandom);
            push_raw(flags);
            for (int i = lrd_pkg::FLAG_COUNT - 1; i >= 0; i--) begin
               if (flags[i]) begin
                  // near distances hit fresh data, far ones the fill
                  ref_dist = ($urandom_range(0, 3) == 0) ? DW'($urandom)
                                                         : DW'($urandom_range(0, 15));
                  len_code = 4'($urandom);
                  push_raw({len_code, ref_dist[11:8]});
                  push_raw(ref_dist[7:0]);
               end else begin
                  push_raw(BW'($urandom));
               end
            end
         end
         if (kind < 30) begin
            cut = $urandom_range(1, stream_q.size());
            while (stream_q.size() > cut)
               void'(stream_q.pop_back());
         end
      end
      stream_q[stream_q.size() - 1].eos = 1'b1;
   endtask

   task automatic send_word(input stim_word_type w);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.in_byte <= w.data;
      req_ch.in_last <= w.eos;
      stim_q.push_back(w);
      do @(posedge clock); while (!req_ch.ready);
      words_sent++;
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (exp_q.size() != 0 || stim_q.size() != 0);
   endtask

   // result side: stalls of random length, some stretches without any
   initial begin : rsp_stall
      int stall;
      forever begin
         stall = pick_gap();
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   always @(posedge clock) begin : monitor
      stim_word_type w;
      dec_byte_type  want;
      dec_byte_type  item;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            if (stim_q.size() == 0) begin
               report_mismatch("input word accepted with none driven");
            end else begin
               w = stim_q.pop_front();
               decode_word(w.data, w.eos);
               if (w.typed) begin
                  for (int i = 0; i < w.n_typed; i++) begin
                     item = '{w.typed_byte, i == w.n_typed - 1};
                     exp_q.push_back(item);
                  end
               end else begin
                  foreach (step_bytes[i]) begin
                     item = '{step_bytes[i], i == step_bytes.size() - 1};
                     exp_q.push_back(item);
                  end
               end
            end
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (exp_q.size() == 0) begin
               report_mismatch($sformatf("unexpected byte %02h last=%0b",
                                         rsp_ch.out_byte, rsp_ch.out_last));
            end else begin
               want = exp_q.pop_front();
               bytes_checked++;
               if (rsp_ch.out_byte !== want.data)
                  report_mismatch($sformatf("out_byte %02h, expected %02h",
                                            rsp_ch.out_byte, want.data));
               if (rsp_ch.out_last !== want.eos)
                  report_mismatch($sformatf("out_last %0b, expected %0b",
                                            rsp_ch.out_last, want.eos));
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
         $display("lzss_ring_decompressor: mismatch");
         $finish;
      end
   end

   initial begin : stimulus
      int n_stream;
      calm           = 1'b0;
      n_stream       = 0;
      clear_history();
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.in_byte <= '0;
      req_ch.in_last <= 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_table[i])
         send_word(dir_table[i]);
      streams_sent = 3;
      // hold the sender until every decoded byte is out
      req_ch.valid <= 1'b0;
      wait_drained();

      while (words_sent < DIRECTED_WORDS + RANDOM_WORDS) begin
         make_stream();
         calm = ($urandom_range(0, 4) == 0);
         if (n_stream == 3) begin
            req_ch.valid <= 1'b0;
            wait_drained();
         end
         foreach (stream_q[i])
            send_word(stream_q[i]);
         n_stream++;
         streams_sent++;
      end
      calm = 1'b0;

      req_ch.valid <= 1'b0;
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (exp_q.size() != 0)
         report_mismatch($sformatf("%0d decoded bytes never came", exp_q.size()));

      $display("Sent %0d compressed words in %0d streams, checked %0d decoded bytes.",
               words_sent, streams_sent, bytes_checked);
      $display("Covered zero and full limits, cut-off references, header-only streams.");
      if (mismatch_cnt == 0)
         $display("lzss_ring_decompressor: match");
      else
         $display("lzss_ring_decompressor: mismatch");
      $finish;
   end

endmodule
